// ===== design/mtfm_pkg.sv =====
// Shared types and constants for the MQTT topic filter matcher.
// No dependencies; imported by mtfm_cell, the top level and the checker.
`default_nettype none

package mtfm_pkg;

  localparam logic [7:0] SEP_CHAR  = 8'h2F;
  localparam logic [7:0] HASH_CHAR = 8'h23;
  localparam logic [7:0] PLUS_CHAR = 8'h2B;

  localparam logic MODE_FILTER  = 1'b0;
  localparam logic MODE_SUBJECT = 1'b1;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic       ld;        // filter request accepted
    logic       begin_f;   // that request starts a new filter
    logic       fbyte;     // filter character
    logic       fsep;      // filter separator
    logic       sstep;     // subject step (request or deferred close)
    logic       sbyte;     // subject character to compare
    logic       sclose;    // subject level closes
    logic       close_ok;  // close updates the match row
    logic       fresh;     // match row is still at its restart value
    logic [7:0] data;
  } mtfm_ctl_t;

  // neighbor link, left to right
  typedef struct packed {
    logic tok;   // load position moves right
    logic base;  // restart row bit
    logic row;   // current row bit
    logic nx;    // row bit after close
  } mtfm_link_t;

endpackage

`default_nettype wire

// ===== design/mtfm_cell.sv =====
// One filter level cell: holds the level text, its kind and one match-row bit.
// Depends on mtfm_pkg; chained by mqtt_topic_filter_match.
`default_nettype none

module mtfm_cell
  import mtfm_pkg::*;
#(
  parameter int MAX_LEVEL_BYTES = 32,
  localparam int LENW = $clog2(MAX_LEVEL_BYTES + 1),
  localparam int IDXW = (MAX_LEVEL_BYTES > 1) ? $clog2(MAX_LEVEL_BYTES) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head,
  input  logic            tail,
  input  mtfm_ctl_t       ctl,
  input  logic [LENW-1:0] cp,
  input  logic [LENW-1:0] cp_byte,
  input  logic [IDXW-1:0] rd_addr,
  input  mtfm_link_t      left,
  output mtfm_link_t      right,
  output logic            cur,
  output logic            ovf,
  output logic            row_new
);

  logic            active;
  logic [LENW-1:0] len;
  logic            hash_c;
  logic            plus_c;
  logic            eq;
  logic            row;
  logic [7:0]      chars [MAX_LEVEL_BYTES];
  logic [7:0]      rdata;

  logic            active_eff;
  logic            active_next;
  logic [LENW-1:0] len_eff;
  logic            room;
  logic            wr;
  logic            kind_hash;
  logic            kind_plus;
  logic            row_eff;
  logic            eq_byte;
  logic            nx;

  always_comb begin
    active_eff  = ctl.begin_f ? head : active;
    len_eff     = (ctl.begin_f && head) ? '0 : len;
    room        = len_eff < LENW'(MAX_LEVEL_BYTES);
    wr          = ctl.fbyte && active_eff && room;
    active_next = ctl.fsep ? (left.tok || (tail && active_eff)) : active_eff;
    ovf         = ctl.ld && active_eff && ((ctl.fsep && tail) || (ctl.fbyte && !room));

    kind_hash = (len == LENW'(1)) && hash_c;
    kind_plus = (len == LENW'(1)) && plus_c;

    row_eff = ctl.fresh ? (kind_hash && left.base) : row;
    eq_byte = ctl.sbyte ? (eq && (cp < len) && (rdata == ctl.data)) : eq;

    if (kind_hash) begin
      nx = left.nx || row_eff || left.row;
    end else if (kind_plus) begin
      nx = left.row;
    end else begin
      nx = eq_byte && (len == cp_byte) && left.row;
    end

    right.tok  = active_eff && ctl.fsep;
    right.base = kind_hash && left.base;
    right.row  = row_eff;
    right.nx   = nx;
    row_new    = ctl.close_ok ? nx : row_eff;
    cur        = active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= head;
      len    <= '0;
      hash_c <= 1'b0;
      plus_c <= 1'b0;
      eq     <= 1'b1;
    end else if (ctl.ld) begin
      active <= active_next;
      if (ctl.fsep && left.tok) begin
        len <= '0;
      end else if (wr) begin
        len <= len_eff + LENW'(1);
      end else begin
        len <= len_eff;
      end
      if (wr && (len_eff == '0)) begin
        hash_c <= (ctl.data == HASH_CHAR);
        plus_c <= (ctl.data == PLUS_CHAR);
      end
      eq <= 1'b1;
    end else if (ctl.sstep) begin
      eq <= ctl.sclose ? 1'b1 : eq_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sstep) begin
      row <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      chars[len_eff[IDXW-1:0]] <= ctl.data;
    end
    if (wr && (len_eff[IDXW-1:0] == rd_addr)) begin
      rdata <= ctl.data;
    end else begin
      rdata <= chars[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/mqtt_topic_filter_match.sv =====
// Top level of the MQTT topic filter matcher: control, counters and the cell chain.
// Depends on mtfm_pkg and mtfm_cell.
//
// Usage:
//   Input stream s_*: one character request per cycle. s_tuser = 0 for filter
//   characters, 1 for subject characters; s_tlast ends a string. s_tdata[8]
//   says whether s_tdata[7:0] carries a character (clear it to end an empty
//   string). The filter stays loaded for any number of subjects; a filter
//   request after a finished filter starts a new one.
//   Output stream m_*: one result per subject, m_tdata[0] matched,
//   m_tdata[1] overflow (too many levels or too long a level; matched is 0).
//   Result: registered from the subject's last request; when that last
//   request carries '/', the deferred second level close (pend) comes between.
//   Throughput: one request per cycle while s_tready is high; a subject whose
//   last request is '/' holds s_tready low for the second level close.
//   Each cell compares its level text against the subject byte in parallel,
//   and the match row ripples combinationally through the cell chain.
//   Reset: the filter is one empty level, no result pending.
//   Stall: while a result waits on m_tready, s_tready stays low.
`default_nettype none

module mqtt_topic_filter_match
  import mtfm_pkg::*;
#(
  parameter int MAX_LEVELS      = 16,
  parameter int MAX_LEVEL_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] byte_valid, [15:9] zero
  input  logic        s_tlast,
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] matched, [1] overflow, [7:2] zero
);

  localparam int LENW = $clog2(MAX_LEVEL_BYTES + 1);
  localparam int IDXW = (MAX_LEVEL_BYTES > 1) ? $clog2(MAX_LEVEL_BYTES) : 1;
  localparam int SLW  = $clog2(MAX_LEVELS + 1);

  logic            load_mode;
  logic            fresh;
  logic            r0;
  logic [LENW-1:0] cp;
  logic [SLW-1:0]  sl;
  logic            ovf_f;
  logic            ovf_s;
  logic            pend;

  mtfm_ctl_t       ctl;
  mtfm_link_t      lnk [MAX_LEVELS+1];
  logic [MAX_LEVELS-1:0] cell_cur;
  logic [MAX_LEVELS-1:0] cell_ovf;
  logic [MAX_LEVELS-1:0] cell_row;

  logic            slot_free;
  logic            acc_f;
  logic            acc_s;
  logic            pend_fire;
  logic            is_sep;
  logic            bvalid;
  logic            s_char;
  logic            cp_full;
  logic            lvl_full;
  logic            done;
  logic            split;
  logic            r0_eff;
  logic            ovf_s_new;
  logic            ovf_f_new;
  logic            ovf_all;
  logic            hit;
  logic [LENW-1:0] cp_byte;
  logic [LENW-1:0] cp_next;

  always_comb begin
    slot_free = !m_tvalid || m_tready;
    s_tready  = !pend && slot_free;
    acc_f     = s_tvalid && s_tready && (s_tuser == MODE_FILTER);
    acc_s     = s_tvalid && s_tready && (s_tuser == MODE_SUBJECT);
    pend_fire = pend && slot_free;
    bvalid    = s_tdata[8];
    is_sep    = s_tdata[7:0] == SEP_CHAR;
    s_char    = acc_s && bvalid && !is_sep;
    cp_full   = cp >= LENW'(MAX_LEVEL_BYTES);
    lvl_full  = sl >= SLW'(MAX_LEVELS);

    ctl.ld       = acc_f;
    ctl.begin_f  = acc_f && !load_mode;
    ctl.fbyte    = acc_f && bvalid && !is_sep;
    ctl.fsep     = acc_f && bvalid && is_sep;
    ctl.sstep    = acc_s || pend_fire;
    ctl.sbyte    = s_char && !cp_full;
    ctl.sclose   = (acc_s && ((bvalid && is_sep) || s_tlast)) || pend_fire;
    ctl.close_ok = ctl.sclose && !lvl_full;
    ctl.fresh    = fresh;
    ctl.data     = s_tdata[7:0];

    cp_byte = ctl.sbyte ? cp + LENW'(1) : cp;
    if (acc_f || (ctl.sstep && ctl.sclose)) begin
      cp_next = '0;
    end else if (ctl.sstep) begin
      cp_next = cp_byte;
    end else begin
      cp_next = cp;
    end

    done  = (acc_s && s_tlast && !(bvalid && is_sep)) || pend_fire;
    split = acc_s && s_tlast && bvalid && is_sep;

    r0_eff    = fresh ? 1'b1 : r0;
    ovf_s_new = ovf_s || (s_char && cp_full) || (ctl.sclose && lvl_full);
    ovf_f_new = (ctl.begin_f ? 1'b0 : ovf_f) || (|cell_ovf);
    ovf_all   = ovf_f || ovf_s_new;
    hit       = |(cell_cur & cell_row);

    lnk[0].tok  = 1'b0;
    lnk[0].base = 1'b1;
    lnk[0].row  = r0_eff;
    lnk[0].nx   = 1'b0;
  end

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    mtfm_cell #(
      .MAX_LEVEL_BYTES (MAX_LEVEL_BYTES)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .head    (i == 0),
      .tail    (i == MAX_LEVELS - 1),
      .ctl     (ctl),
      .cp      (cp),
      .cp_byte (cp_byte),
      .rd_addr (cp_next[IDXW-1:0]),
      .left    (lnk[i]),
      .right   (lnk[i+1]),
      .cur     (cell_cur[i]),
      .ovf     (cell_ovf[i]),
      .row_new (cell_row[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_mode <= 1'b0;
      fresh     <= 1'b1;
      r0        <= 1'b1;
      cp        <= '0;
      sl        <= '0;
      ovf_f     <= 1'b0;
      ovf_s     <= 1'b0;
      pend      <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (acc_f) begin
        load_mode <= !s_tlast;
      end else if (acc_s) begin
        load_mode <= 1'b0;
      end

      if (split) begin
        pend <= 1'b1;
      end else if (pend_fire) begin
        pend <= 1'b0;
      end

      cp <= cp_next;

      if (acc_f || done) begin
        sl <= '0;
      end else if (ctl.close_ok) begin
        sl <= sl + SLW'(1);
      end

      if (acc_f) begin
        ovf_f <= ovf_f_new;
      end

      if (acc_f || done) begin
        ovf_s <= 1'b0;
        fresh <= 1'b1;
      end else if (ctl.sstep) begin
        ovf_s <= ovf_s_new;
        fresh <= 1'b0;
      end

      if (ctl.sstep) begin
        r0 <= ctl.close_ok ? 1'b0 : r0_eff;
      end

      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {6'b0, ovf_all, !ovf_all && hit};
    end
  end

endmodule

`default_nettype wire

// ===== design/mtfm_checker.sv =====
// Port-level checks for mqtt_topic_filter_match, bound to the top level.
// Depends on mtfm_pkg.
`default_nettype none

module mtfm_checker
  import mtfm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  logic subj_end;
  assign subj_end = s_tvalid && s_tready && (s_tuser == MODE_SUBJECT) && s_tlast;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_ovf_nomatch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("match reported with overflow");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(subj_end) || $past(subj_end, 2)))
    else $error("result without a subject end request");

  a_no_take: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken while result stalled");

endmodule

bind mqtt_topic_filter_match mtfm_checker u_checker (.*);

`default_nettype wire

// ===== test/tb_mqtt_topic_filter_match.sv =====
// Testbench for mqtt_topic_filter_match: streams topic filters and subjects,
// predicts each match/overflow result and checks it. Depends on mtfm_pkg
// and the top level in design/.
`timescale 1ns / 100ps

module tb_mqtt_topic_filter_match;
  import mtfm_pkg::*;

  localparam int LEVELS      = 16;
  localparam int LEVEL_BYTES = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 1000;

  typedef logic [7:0] byte_q_t[$];
  typedef enum logic [1:0] {LVL_LITERAL, LVL_PLUS, LVL_HASH} lvl_kind_e;
  typedef struct {
    logic matched;
    logic overflow;
  } topic_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tlast;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  mqtt_topic_filter_match #(
    .MAX_LEVELS(LEVELS),
    .MAX_LEVEL_BYTES(LEVEL_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  lvl_kind_e         f_kind[LEVELS];
  logic [7:0]        f_text[LEVELS][LEVEL_BYTES];
  int                f_len[LEVELS];
  int                f_count;
  logic [LEVELS:0]   match_row;
  logic [LEVELS-1:0] still_eq;
  int                subj_pos;
  int                subj_levels;
  bit                loading;
  bit                filt_ovf;
  bit                subj_ovf;

  topic_result_t expected_matches[$];
  int            errors;
  int            sent;
  int            idle_cycles;
  bit            idle_on;
  int            rx_hold;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic void restart_subject();
    int i;
    match_row = '0;
    match_row[0] = 1'b1;
    for (i = 1; i <= f_count; i++)
      match_row[i] = (f_kind[i-1] == LVL_HASH) && match_row[i-1];
    still_eq = '1;
    subj_pos = 0;
    subj_levels = 0;
    subj_ovf = 1'b0;
  endfunction

  function automatic void seal_filter();
    int i;
    for (i = 0; i < f_count; i++) begin
      f_kind[i] = LVL_LITERAL;
      if (f_len[i] == 1 && f_text[i][0] == HASH_CHAR) f_kind[i] = LVL_HASH;
      else if (f_len[i] == 1 && f_text[i][0] == PLUS_CHAR) f_kind[i] = LVL_PLUS;
    end
    loading = 1'b0;
    restart_subject();
  endfunction

  function automatic void close_subject_level();
    logic [LEVELS:0] nxt;
    int i;
    if (subj_levels >= LEVELS) begin
      subj_ovf = 1'b1;
    end else begin
      nxt = '0;
      for (i = 1; i <= f_count; i++) begin
        case (f_kind[i-1])
          LVL_HASH: nxt[i] = nxt[i-1] | match_row[i] | match_row[i-1];
          LVL_PLUS: nxt[i] = match_row[i-1];
          default:  nxt[i] = still_eq[i-1] && f_len[i-1] == subj_pos && match_row[i-1];
        endcase
      end
      match_row = nxt;
      subj_levels++;
    end
    still_eq = '1;
    subj_pos = 0;
  endfunction

  function automatic void predict_topic_match(input logic mode, input logic [7:0] ch,
                                              input logic has_char, input logic ends);
    topic_result_t r;
    int i;
    int cur;
    if (mode == MODE_FILTER) begin
      if (!loading) begin
        f_count = 1;
        f_len[0] = 0;
        filt_ovf = 1'b0;
        subj_ovf = 1'b0;
        loading = 1'b1;
      end
      if (has_char) begin
        cur = f_count - 1;
        if (ch == SEP_CHAR) begin
          if (f_count < LEVELS) begin
            f_len[f_count] = 0;
            f_count++;
          end else begin
            filt_ovf = 1'b1;
          end
        end else if (f_len[cur] < LEVEL_BYTES) begin
          f_text[cur][f_len[cur]] = ch;
          f_len[cur]++;
        end else begin
          filt_ovf = 1'b1;
        end
      end
      if (ends) seal_filter();
    end else begin
      if (loading) seal_filter();
      if (has_char) begin
        if (ch == SEP_CHAR) begin
          close_subject_level();
        end else if (subj_pos >= LEVEL_BYTES) begin
          subj_ovf = 1'b1;
        end else begin
          for (i = 0; i < f_count; i++)
            if (subj_pos >= f_len[i] || f_text[i][subj_pos] != ch) still_eq[i] = 1'b0;
          subj_pos++;
        end
      end
      if (ends) begin
        close_subject_level();
        r.overflow = filt_ovf | subj_ovf;
        r.matched  = !r.overflow && match_row[f_count];
        expected_matches.push_back(r);
        restart_subject();
      end
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_matches.size() == 0) begin
        report_mismatch("result with none pending", m_tdata, 0);
      end else begin
        if (m_tdata[0] !== expected_matches[0].matched)
          report_mismatch("matched", m_tdata[0], expected_matches[0].matched);
        if (m_tdata[1] !== expected_matches[0].overflow)
          report_mismatch("overflow", m_tdata[1], expected_matches[0].overflow);
        void'(expected_matches.pop_front());
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold--;
      m_tready = 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      rx_hold = $urandom_range(1, 14) - 1;
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  // watchdog: cycles with no request and no result accepted
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_req(input logic mode, input logic [7:0] ch, input logic has_char,
                          input logic ends);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 11) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tdata  = {7'b0, has_char, ch};
    s_tuser  = mode;
    s_tlast  = ends;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_topic_match(mode, ch, has_char, ends);
    sent++;
  endtask

  task automatic send_text(input logic mode, input byte_q_t txt, input bit close,
                           input bit ragged);
    int i;
    int n;
    bit tail;
    n = txt.size();
    tail = close && (n == 0 || (ragged && $urandom_range(0, 3) == 0));
    for (i = 0; i < n; i++) begin
      if (ragged && $urandom_range(0, 7) == 0) send_req(mode, 8'($urandom), 1'b0, 1'b0);
      send_req(mode, txt[i], 1'b1, close && !tail && i == n - 1);
    end
    if (tail) send_req(mode, 8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
  endtask

  function automatic byte_q_t to_bytes(input string s);
    byte_q_t q;
    int i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic byte_q_t fill(input logic [7:0] c, input int n);
    byte_q_t q;
    int i;
    for (i = 0; i < n; i++) q.push_back(c);
    return q;
  endfunction

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 15);
    if (r < 10) return 8'h61 + 8'(r % 3);
    if (r == 10) return PLUS_CHAR;
    if (r == 11) return HASH_CHAR;
    return 8'($urandom);
  endfunction

  function automatic byte_q_t rand_word(input int lo, input int hi);
    byte_q_t q;
    int i;
    int n;
    n = $urandom_range(lo, hi);
    for (i = 0; i < n; i++) q.push_back(rand_char());
    return q;
  endfunction

  function automatic void append_level(ref byte_q_t q, ref bit first, input byte_q_t w);
    if (!first) q.push_back(SEP_CHAR);
    first = 1'b0;
    q = {q, w};
  endfunction

  task automatic test_reset_state();
    send_text(MODE_SUBJECT, to_bytes(""), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("a"), 1, 0);
  endtask

  task automatic test_literal_levels();
    send_text(MODE_FILTER, to_bytes("a/b"), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("a/b"), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("a/c"), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("a/b/"), 1, 0);
    send_text(MODE_FILTER, '{8'h00, 8'hFF}, 1, 0);
    send_text(MODE_SUBJECT, '{8'h00, 8'hFF}, 1, 0);
    send_text(MODE_SUBJECT, '{8'hFF, 8'h00}, 1, 0);
  endtask

  task automatic test_wildcards();
    send_text(MODE_FILTER, to_bytes("+/#"), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("x"), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("x/y/z"), 1, 0);
    send_text(MODE_FILTER, to_bytes("a/+"), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("a/"), 1, 0);
    send_text(MODE_FILTER, to_bytes("#"), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("/"), 1, 0);
  endtask

  task automatic test_empty_strings();
    send_text(MODE_FILTER, to_bytes(""), 1, 0);
    send_text(MODE_SUBJECT, to_bytes(""), 1, 0);
    send_text(MODE_FILTER, to_bytes("/"), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("/"), 1, 0);
    send_text(MODE_SUBJECT, to_bytes(""), 1, 0);
  endtask

  task automatic test_new_filter_abort();
    send_text(MODE_FILTER, to_bytes("a"), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("a/b"), 0, 0);
    send_text(MODE_FILTER, to_bytes("b"), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("b"), 1, 0);
  endtask

  task automatic test_subject_during_load();
    send_text(MODE_FILTER, to_bytes("+/x"), 0, 0);
    send_text(MODE_SUBJECT, to_bytes("q/x"), 1, 0);
  endtask

  task automatic test_overflow();
    send_text(MODE_FILTER, fill(SEP_CHAR, LEVELS), 1, 0);
    send_text(MODE_SUBJECT, fill(SEP_CHAR, LEVELS - 1), 1, 0);
    send_text(MODE_SUBJECT, to_bytes(""), 1, 0);
    send_text(MODE_FILTER, to_bytes("#"), 1, 0);
    send_text(MODE_SUBJECT, fill(SEP_CHAR, LEVELS), 1, 0);
    send_text(MODE_SUBJECT, fill(8'h61, LEVEL_BYTES + 1), 1, 0);
    send_text(MODE_SUBJECT, to_bytes("a"), 1, 0);
    send_text(MODE_FILTER, fill(8'h62, LEVEL_BYTES + 1), 1, 0);
    send_text(MODE_SUBJECT, fill(8'h62, LEVEL_BYTES), 1, 0);
  endtask

  task automatic test_random_traffic(input int target);
    lvl_kind_e lvl_kind[20];
    byte_q_t   lvl_word[20];
    byte_q_t   filt;
    byte_q_t   subj;
    bit        first;
    bit        big;
    bit        drained;
    int        nlev;
    int        nsub;
    int        r;
    int        k;
    int        j;
    int        m;
    drained = 0;
    while (sent < target) begin
      idle_on = !(sent >= target - 150 || (sent >= 300 && sent < 380));
      if (!drained && sent >= 450) begin
        wait_for_results();
        drained = 1;
      end
      r = $urandom_range(0, 19);
      if (r == 16) begin
        repeat ($urandom_range(1, 20))
          send_req(1'($urandom), 8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        big = (r == 19) || ($urandom_range(0, 15) == 0);
        nlev = big ? $urandom_range(LEVELS - 2, LEVELS + 3) : $urandom_range(1, 4);
        filt.delete();
        first = 1;
        for (k = 0; k < nlev; k++) begin
          m = $urandom_range(0, 9);
          lvl_word[k].delete();
          if (m < 2) begin
            lvl_kind[k] = LVL_PLUS;
            append_level(filt, first, '{PLUS_CHAR});
          end else if (m == 2) begin
            lvl_kind[k] = LVL_HASH;
            append_level(filt, first, '{HASH_CHAR});
          end else begin
            lvl_kind[k] = LVL_LITERAL;
            lvl_word[k] = (big && $urandom_range(0, 3) == 0) ? rand_word(30, 40)
                                                             : rand_word(0, 3);
            append_level(filt, first, lvl_word[k]);
          end
        end
        send_text(MODE_FILTER, filt, r != 18, $urandom_range(0, 3) == 0);
        nsub = $urandom_range(1, 4);
        for (j = 0; j < nsub; j++) begin
          subj.delete();
          first = 1;
          for (k = 0; k < nlev; k++) begin
            case (lvl_kind[k])
              LVL_PLUS: append_level(subj, first, rand_word(0, big ? 40 : 3));
              LVL_HASH:
                repeat ($urandom_range(0, 3)) append_level(subj, first, rand_word(0, 3));
              default:
                append_level(subj, first, ($urandom_range(0, 6) != 0) ? lvl_word[k]
                                                                      : rand_word(0, 3));
            endcase
          end
          if ($urandom_range(0, 7) == 0) append_level(subj, first, rand_word(0, 3));
          send_text(MODE_SUBJECT, subj, !(r == 17 && j == nsub - 1),
                    $urandom_range(0, 3) == 0);
        end
      end
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    s_tuser  = 1'b0;
    m_tready = 1'b1;
    rx_hold  = 0;
    idle_on  = 1'b1;
    errors   = 0;
    sent     = 0;
    foreach (f_kind[i]) f_kind[i] = LVL_LITERAL;
    foreach (f_len[i]) f_len[i] = 0;
    foreach (f_text[i, j]) f_text[i][j] = '0;
    f_count  = 1;
    loading  = 1'b0;
    filt_ovf = 1'b0;
    restart_subject();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_literal_levels();
    test_wildcards();
    test_empty_strings();
    test_new_filter_abort();
    test_subject_during_load();
    test_overflow();
    test_random_traffic(ITEM_TARGET);

    wait_for_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
